// ===== src/nmea_sentence_checksum_framer_core_assert.svh =====
// Assertion macros shared by the framer RTL.
`ifndef NMEA_SENTENCE_CHECKSUM_FRAMER_CORE_ASSERT_SVH
`define NMEA_SENTENCE_CHECKSUM_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define NSCF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define NSCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/nscf_pkg.sv =====
// Types and constants of the NMEA sentence checksum framer.
`default_nettype none

package nscf_pkg;

	// Size of the sentence buffer in bytes.
	localparam int unsigned SENTENCE_BYTES = 128;

	localparam int unsigned HDR_BYTES = 6;
	localparam int unsigned HDR_W     = 8 * HDR_BYTES;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned NUM_KINDS = 4;

	// Characters with a special meaning in the stream.
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_GGA = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_GSA = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_RMC = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_VTG = 8'd3;

	// Header words after reset: $GPGGA, $GPGSA, $GPRMC, $GPVTG.
	localparam logic [HDR_W-1:0] HDR_RST_GGA = 48'h244750474741;
	localparam logic [HDR_W-1:0] HDR_RST_GSA = 48'h244750475341;
	localparam logic [HDR_W-1:0] HDR_RST_RMC = 48'h244750524D43;
	localparam logic [HDR_W-1:0] HDR_RST_VTG = 48'h244750565447;

	// Sentence kinds.
	localparam logic [2:0] KIND_GGA   = 3'd0;
	localparam logic [2:0] KIND_GSA   = 3'd1;
	localparam logic [2:0] KIND_RMC   = 3'd2;
	localparam logic [2:0] KIND_VTG   = 3'd3;
	localparam logic [2:0] KIND_OTHER = 3'd4;

	// Checksum phase: body before the star, high digit, low digit, done.
	typedef enum logic [3:0] {
		PH_BODY = 4'b0001,
		PH_HI   = 4'b0010,
		PH_LO   = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	// One result item.
	typedef struct packed {
		logic       checksum_ok;
		logic [2:0] sentence_kind;
		logic [7:0] computed_xor;
		logic [7:0] received_sum;
		logic [7:0] sentence_length;
		logic       overflow_seen;
		logic       restart_seen;
	} result_t;

endpackage

`default_nettype wire

// ===== src/nscf_byte_if.sv =====
// Request channel that carries one received byte.
`default_nettype none

interface nscf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/nscf_result_if.sv =====
// Request channel that carries one sentence result.
`default_nettype none

interface nscf_result_if import nscf_pkg::*; ;
	logic    valid;
	logic    ready;
	result_t res;

	modport source (output valid, output res, input ready);
	modport sink (input valid, input res, output ready);
endinterface

`default_nettype wire

// ===== src/nscf_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface nscf_cfg_if import nscf_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [HDR_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/nmea_sentence_checksum_framer_core.sv =====
// Top level of the NMEA sentence checksum framer.
//
//  channel  dir  payload                          request moves
//  in_ch    in   rx_byte[7:0]                     one received byte
//  out_ch   out  result_t (seven fields)          one result per newline
//  cfg_ch   in   index[7:0], data[47:0]           one header word write
//
// A byte is held in the input register, then the per-byte update
// writes the sentence state and, on a newline, the result register.
// One byte is taken every cycle; the result is offered from the result register.
// Only a newline waits, when the result register is still full.
// Reset clears the sentence state and loads the default header words.
// The configuration channel is always ready.
`default_nettype none
`include "nmea_sentence_checksum_framer_core_assert.svh"

module nmea_sentence_checksum_framer_core import nscf_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	nscf_byte_if.sink    in_ch,
	nscf_result_if.source out_ch,
	nscf_cfg_if.sink     cfg_ch
);

	localparam logic [8:0] LIMIT_OVF  = 9'(SENTENCE_BYTES - 2);
	localparam logic [8:0] LIMIT_BUF  = 9'(SENTENCE_BYTES);
	localparam logic [7:0] POS_OVF    = 8'(SENTENCE_BYTES - 2);

	// Header words.
	logic [HDR_W-1:0] hdr_word_q [NUM_KINDS];

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Sentence state.
	logic [7:0]       pos_q;
	logic [7:0]       xor_q;
	phase_t           phase_q;
	logic [7:0]       hex_q;
	logic             hex_bad_q;
	logic             late_q;
	logic [HDR_W-1:0] hdr_q;
	logic             ovf_q;
	logic             restart_q;

	// Result register.
	logic    out_valid_q;
	result_t res_q;

	// Next-state values.
	logic       is_nl, ignore, restart, adv, res_ld;
	logic [7:0] pos_b, xor_t, hex_t, digit;
	logic       digit_bad, hex_bad_t, late_t, restart_t;
	phase_t     phase_b, phase_t_n;
	logic [HDR_W-1:0] hdr_b, hdr_t, hdr_pad;
	logic [7:0] len;
	logic [8:0] pos_inc;
	logic       digits_ok;
	logic [2:0] kind;
	result_t    res_d;

	// Configuration writes; indexes past the list are dropped.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_word_q[0] <= HDR_RST_GGA;
			hdr_word_q[1] <= HDR_RST_GSA;
			hdr_word_q[2] <= HDR_RST_RMC;
			hdr_word_q[3] <= HDR_RST_VTG;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				CFG_HDR_GGA: hdr_word_q[0] <= cfg_ch.data;
				CFG_HDR_GSA: hdr_word_q[1] <= cfg_ch.data;
				CFG_HDR_RMC: hdr_word_q[2] <= cfg_ch.data;
				CFG_HDR_VTG: hdr_word_q[3] <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// Handshake: only a newline needs a free result register.
	assign is_nl  = (byte_s1 == CH_NL);
	assign res_ld = valid_s1 && is_nl && (!out_valid_q || out_ch.ready);
	assign adv    = valid_s1 && (!is_nl || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.rx_byte;
		end
	end

	// Restart and overflow decide which state the byte works on.
	assign ignore  = !is_nl && ovf_q;
	assign restart = !is_nl && !ovf_q && (byte_s1 == CH_START) && (pos_q != 8'd0);
	assign pos_b   = restart ? 8'd0 : pos_q;
	assign phase_b = restart ? PH_BODY : phase_q;
	assign hdr_b   = restart ? '0 : hdr_q;
	assign restart_t = restart || restart_q;

	// Uppercase hex digit decode.
	always_comb begin
		digit_bad = 1'b0;
		digit     = 8'd0;
		if (byte_s1 >= CH_0 && byte_s1 <= CH_9) begin
			digit = byte_s1 - CH_0;
		end else if (byte_s1 >= CH_A && byte_s1 <= CH_F) begin
			digit = byte_s1 - CH_A + HEX_TEN;
		end else begin
			digit_bad = 1'b1;
		end
	end

	// Header shift and checksum phase for the stored byte.
	always_comb begin
		hdr_t     = hdr_b;
		xor_t     = restart ? 8'd0 : xor_q;
		hex_t     = restart ? 8'd0 : hex_q;
		hex_bad_t = restart ? 1'b0 : hex_bad_q;
		late_t    = restart ? 1'b0 : late_q;
		phase_t_n = phase_b;
		if (pos_b < 8'(HDR_BYTES)) begin
			hdr_t = {hdr_b[HDR_W-9:0], byte_s1};
		end
		if (pos_b != 8'd0) begin
			unique case (phase_b)
				PH_BODY: begin
					if (byte_s1 == CH_STAR) begin
						phase_t_n = PH_HI;
						if ({1'b0, pos_b} + 9'd3 >= LIMIT_BUF) begin
							late_t = 1'b1;
						end
					end else begin
						xor_t = xor_t ^ byte_s1;
					end
				end
				PH_HI: begin
					hex_t     = {digit[3:0], 4'h0};
					hex_bad_t = hex_bad_t | digit_bad;
					phase_t_n = PH_LO;
				end
				PH_LO: begin
					hex_t     = hex_t | {4'h0, digit[3:0]};
					hex_bad_t = hex_bad_t | digit_bad;
					phase_t_n = PH_DONE;
				end
				PH_DONE: ;
				default: ;
			endcase
		end
	end

	// A short sentence is padded with zero bytes after its newline.
	assign len = pos_q + 8'd1;
	always_comb begin
		hdr_pad = hdr_t;
		if (len < 8'(HDR_BYTES)) begin
			unique case (len[2:0])
				3'd1: hdr_pad = {hdr_t[7:0], 40'h0};
				3'd2: hdr_pad = {hdr_t[15:0], 32'h0};
				3'd3: hdr_pad = {hdr_t[23:0], 24'h0};
				3'd4: hdr_pad = {hdr_t[31:0], 16'h0};
				3'd5: hdr_pad = {hdr_t[39:0], 8'h0};
				default: hdr_pad = hdr_t;
			endcase
		end
	end

	// The first matching header word decides the kind.
	always_comb begin
		if (hdr_pad == hdr_word_q[0]) begin
			kind = KIND_GGA;
		end else if (hdr_pad == hdr_word_q[1]) begin
			kind = KIND_GSA;
		end else if (hdr_pad == hdr_word_q[2]) begin
			kind = KIND_RMC;
		end else if (hdr_pad == hdr_word_q[3]) begin
			kind = KIND_VTG;
		end else begin
			kind = KIND_OTHER;
		end
	end

	// Result fields.
	assign digits_ok = (phase_t_n == PH_DONE) && !hex_bad_t && !late_t;
	always_comb begin
		res_d.checksum_ok     = digits_ok && !ovf_q && (hex_t == xor_t);
		res_d.sentence_kind   = kind;
		res_d.computed_xor    = xor_t;
		res_d.received_sum    = digits_ok ? hex_t : 8'd0;
		res_d.sentence_length = len;
		res_d.overflow_seen   = ovf_q;
		res_d.restart_seen    = restart_q;
	end

	assign pos_inc = {1'b0, pos_b} + 9'd1;

	// Sentence state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 8'd0;
			xor_q     <= 8'd0;
			phase_q   <= PH_BODY;
			hex_q     <= 8'd0;
			hex_bad_q <= 1'b0;
			late_q    <= 1'b0;
			hdr_q     <= '0;
			ovf_q     <= 1'b0;
			restart_q <= 1'b0;
		end else if (adv) begin
			if (is_nl) begin
				pos_q     <= 8'd0;
				xor_q     <= 8'd0;
				phase_q   <= PH_BODY;
				hex_q     <= 8'd0;
				hex_bad_q <= 1'b0;
				late_q    <= 1'b0;
				hdr_q     <= '0;
				ovf_q     <= 1'b0;
				restart_q <= 1'b0;
			end else if (!ignore) begin
				pos_q     <= pos_inc[7:0];
				xor_q     <= xor_t;
				phase_q   <= phase_t_n;
				hex_q     <= hex_t;
				hex_bad_q <= hex_bad_t;
				late_q    <= late_t;
				hdr_q     <= hdr_t;
				ovf_q     <= (pos_inc >= LIMIT_OVF);
				restart_q <= restart_t;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.res   = res_q;

	// Checks on the sentence state and the result path.
	`NSCF_ASSERT_IMP(a_pos_bound, 1'b1, pos_q <= POS_OVF, "byte position past buffer limit")
	`NSCF_ASSERT_IMP(a_ovf_pos, ovf_q, pos_q == POS_OVF, "overflow flag away from buffer limit")
	`NSCF_ASSERT_IMP(a_phase_pos, phase_q != PH_BODY, pos_q >= 8'd2, "star seen too early")
	`NSCF_ASSERT_NEXT(a_clear, res_ld, pos_q == 8'd0 && phase_q == PH_BODY && !ovf_q,
		"sentence state not cleared after result")
	`NSCF_ASSERT_NEXT(a_res_valid, res_ld, out_valid_q, "result load lost")

endmodule

`default_nettype wire

// ===== verif/nscf_sentence_sb_pkg.sv =====
// Sentence result predictor and scoreboard for the NMEA checksum framer testbench.
`default_nettype none

package nscf_sentence_sb_pkg;
	import nscf_pkg::*;

	class sentence_scoreboard;
		// Header words as the block should hold them.
		logic [HDR_W-1:0] header_word [NUM_KINDS];

		// Per-sentence state, cleared after every result.
		int unsigned      pos;
		logic [7:0]       xor_acc;
		phase_t           phase;
		logic [7:0]       hex_val;
		bit               hex_bad;
		bit               star_late;
		logic [HDR_W-1:0] hdr_shift;
		bit               overflowed;
		bit               restarted;

		// Sentence results still owed by the block, oldest first.
		result_t pending_sentences [$];

		int unsigned mismatches;
		int unsigned predicted;
		int unsigned checked;
		int unsigned valid_count;
		int unsigned overflow_count;
		int unsigned restart_count;
		int unsigned kind_count [5];

		function new();
			header_word[0] = "$GPGGA";
			header_word[1] = "$GPGSA";
			header_word[2] = "$GPRMC";
			header_word[3] = "$GPVTG";
			clear_sentence();
		endfunction

		function void clear_sentence();
			pos        = 0;
			xor_acc    = '0;
			phase      = PH_BODY;
			hex_val    = '0;
			hex_bad    = 1'b0;
			star_late  = 1'b0;
			hdr_shift  = '0;
			overflowed = 1'b0;
			restarted  = 1'b0;
		endfunction

		// Indexes past the last header word are dropped by the block.
		function void write_header(logic [CFG_IDX_W-1:0] idx, logic [HDR_W-1:0] data);
			if (idx < NUM_KINDS)
				header_word[idx[1:0]] = data;
		endfunction

		// Header and checksum update for one byte stored at the current position.
		function void store_byte(logic [7:0] b);
			logic [3:0] digit;
			if (pos < HDR_BYTES)
				hdr_shift = {hdr_shift[HDR_W-9:0], b};
			// The byte at position zero never takes part in the checksum.
			if (pos >= 1) begin
				case (phase)
					PH_BODY: begin
						if (b == CH_STAR) begin
							phase = PH_HI;
							if (pos + 3 >= SENTENCE_BYTES)
								star_late = 1'b1;
						end else begin
							xor_acc = xor_acc ^ b;
						end
					end
					PH_HI, PH_LO: begin
						if (b >= CH_0 && b <= CH_9) begin
							digit = b[3:0];
						end else if (b >= CH_A && b <= CH_F) begin
							digit = 4'(b - CH_A + HEX_TEN);
						end else begin
							digit   = 4'h0;
							hex_bad = 1'b1;
						end
						if (phase == PH_HI) begin
							hex_val = {digit, 4'h0};
							phase   = PH_LO;
						end else begin
							hex_val[3:0] = digit;
							phase        = PH_DONE;
						end
					end
					default: ;
				endcase
			end
		endfunction

		// Takes one accepted byte request; a newline queues the sentence result.
		function void note_rx_byte(logic [7:0] b);
			result_t          res;
			logic [HDR_W-1:0] hdr;
			int unsigned      len;
			int               k;
			bit               digits_ok;
			if (b != CH_NL) begin
				// After an overflow only the newline counts.
				if (overflowed)
					return;
				if (b == CH_START && pos != 0) begin
					clear_sentence();
					restarted = 1'b1;
				end
				store_byte(b);
				pos++;
				if (pos >= SENTENCE_BYTES - 2)
					overflowed = 1'b1;
				return;
			end

			store_byte(b);
			len = pos + 1;
			hdr = hdr_shift;
			// Short sentences are padded with zero bytes before the compare.
			if (len < HDR_BYTES)
				hdr = hdr << (8 * (HDR_BYTES - len));
			// Scan backwards so the first matching word wins.
			res.sentence_kind = KIND_OTHER;
			for (k = NUM_KINDS; k > 0; k--) begin
				if (hdr == header_word[k-1])
					res.sentence_kind = 3'(k - 1);
			end
			digits_ok = (phase == PH_DONE) && !hex_bad && !star_late;
			res.checksum_ok     = digits_ok && !overflowed && (hex_val == xor_acc);
			res.computed_xor    = xor_acc;
			res.received_sum    = digits_ok ? hex_val : 8'h00;
			res.sentence_length = 8'(len);
			res.overflow_seen   = overflowed;
			res.restart_seen    = restarted;
			pending_sentences.push_back(res);

			predicted++;
			valid_count    += res.checksum_ok;
			overflow_count += res.overflow_seen;
			restart_count  += res.restart_seen;
			kind_count[res.sentence_kind]++;
			clear_sentence();
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("sentence %0d: %s is %0h, expected %0h",
					checked, name, got, want));
		endtask

		// Checks one accepted result request against the oldest prediction.
		task check_sentence_result(result_t got);
			result_t want;
			if (pending_sentences.size() == 0) begin
				report_mismatch($sformatf("result %h with no sentence pending", got));
				return;
			end
			want = pending_sentences.pop_front();
			compare_field("checksum_ok", 8'(got.checksum_ok), 8'(want.checksum_ok));
			compare_field("sentence_kind", 8'(got.sentence_kind), 8'(want.sentence_kind));
			compare_field("computed_xor", got.computed_xor, want.computed_xor);
			compare_field("received_sum", got.received_sum, want.received_sum);
			compare_field("sentence_length", got.sentence_length, want.sentence_length);
			compare_field("overflow_seen", 8'(got.overflow_seen), 8'(want.overflow_seen));
			compare_field("restart_seen", 8'(got.restart_seen), 8'(want.restart_seen));
			checked++;
		endtask
	endclass

endpackage

`default_nettype wire

// ===== verif/tb_nmea_sentence_checksum_framer_core.sv =====
// Testbench top: random NMEA byte streams against a sentence result predictor.
`default_nettype none

module tb_nmea_sentence_checksum_framer_core;
	import nscf_pkg::*;
	import nscf_sentence_sb_pkg::*;

	localparam int unsigned PHASE_BYTES   = 440;
	localparam int unsigned IDLE_SETTLE   = 6;
	localparam int unsigned TIMEOUT_UNITS = 1000000;

	// Split of the random sentence shapes over a 0..99 pick.
	localparam int unsigned PICK_BAD_DIGIT = 60;
	localparam int unsigned PICK_NO_STAR   = 68;
	localparam int unsigned PICK_NO_DIGIT  = 74;
	localparam int unsigned PICK_RESTART   = 79;
	localparam int unsigned PICK_LATE_STAR = 86;
	localparam int unsigned PICK_NOISE     = 92;

	// Receiver stall patterns.
	localparam int unsigned STALL_NONE     = 0;
	localparam int unsigned STALL_COIN     = 1;
	localparam int unsigned STALL_PERIODIC = 2;
	localparam int unsigned STALL_HEAVY    = 3;

	localparam logic [7:0]           CH_Z        = 8'h5A;
	localparam logic [7:0]           CH_LOWER_A  = 8'h61;
	localparam logic [7:0]           CH_LOWER_F  = 8'h66;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #1 clk = ~clk;

	nscf_byte_if   in_ch ();
	nscf_result_if out_ch ();
	nscf_cfg_if    cfg_ch ();

	nmea_sentence_checksum_framer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	sentence_scoreboard sb;
	logic [7:0]  stim_q [$];
	int unsigned bytes_sent = 0;

	int unsigned stall_mode = STALL_NONE;
	int unsigned mode_left  = 0;
	int unsigned stall_tick = 0;

	// Result monitor and receiver stall pattern.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_sentence_result(out_ch.res);
		stall_tick <= stall_tick + 1;
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(STALL_NONE, STALL_HEAVY);
			mode_left  <= $urandom_range(20, 120);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_COIN:     out_ch.ready <= ($urandom_range(0, 1) == 1);
			STALL_PERIODIC: out_ch.ready <= ((stall_tick % 7) < 3);
			STALL_HEAVY:    out_ch.ready <= ($urandom_range(0, 7) == 0);
			default:        out_ch.ready <= 1'b1;
		endcase
	end

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(32, 126));
		while (c == CH_STAR || c == CH_START);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v);
		return (v < HEX_TEN) ? CH_0 + v : CH_A + v - HEX_TEN;
	endfunction

	// A start character followed by five uppercase letters.
	function automatic logic [HDR_W-1:0] ascii_header();
		logic [HDR_W-1:0] w;
		int               k;
		w[HDR_W-1 -: 8] = CH_START;
		for (k = 0; k < HDR_BYTES - 1; k++)
			w[8*k +: 8] = 8'($urandom_range(CH_A, CH_Z));
		return w;
	endfunction

	function automatic logic [HDR_W-1:0] rand_word();
		return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom())};
	endfunction

	function automatic void push_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			stim_q.push_back(s[i]);
	endfunction

	// Appends one random sentence, well formed with random content or broken.
	function automatic void add_sentence();
		logic [7:0]       line [$];
		logic [HDR_W-1:0] word;
		logic [7:0]       sum;
		int unsigned      pick;
		int unsigned      n;
		int unsigned      k;
		pick = $urandom_range(0, 99);
		if (pick >= PICK_NOISE) begin
			// Raw bytes of any value, then a newline.
			n = $urandom_range(1, 20);
			repeat (n) line.push_back(8'($urandom_range(0, 255)));
			line.push_back(CH_NL);
		end else begin
			// Garbage before the header so that its start character restarts.
			if (pick >= PICK_RESTART && pick < PICK_LATE_STAR) begin
				if ($urandom_range(0, 1) == 1)
					line.push_back(CH_START);
				repeat ($urandom_range(1, 10)) line.push_back(body_char());
			end
			if ($urandom_range(0, 3) != 0)
				word = sb.header_word[$urandom_range(0, NUM_KINDS - 1)];
			else
				word = ascii_header();
			for (k = 0; k < HDR_BYTES; k++)
				line.push_back(word[HDR_W-1-8*k -: 8]);

			// Late-star sentences put the star near or past the buffer limit.
			if (pick >= PICK_LATE_STAR)
				n = $urandom_range(118, 130) - line.size();
			else
				n = $urandom_range(0, 24);
			repeat (n) line.push_back(body_char());

			if (pick >= PICK_NO_STAR && pick < PICK_NO_DIGIT) begin
				line.push_back(CH_NL);
			end else begin
				sum = 8'h00;
				for (k = 1; k < line.size(); k++)
					sum = sum ^ line[k];
				if ($urandom_range(0, 6) == 0)
					sum = 8'($urandom_range(0, 255));
				line.push_back(CH_STAR);
				if (pick >= PICK_NO_DIGIT && pick < PICK_RESTART) begin
					if ($urandom_range(0, 1) == 1)
						line.push_back(hex_char(sum[7:4]));
				end else if (pick >= PICK_BAD_DIGIT && pick < PICK_NO_STAR) begin
					if ($urandom_range(0, 1) == 1)
						sum = 8'($urandom_range(CH_LOWER_A, CH_LOWER_F));
					else
						sum = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 1) == 1) begin
						line.push_back(sum);
						line.push_back(hex_char(sum[3:0]));
					end else begin
						line.push_back(hex_char(sum[7:4]));
						line.push_back(sum);
					end
				end else begin
					line.push_back(hex_char(sum[7:4]));
					line.push_back(hex_char(sum[3:0]));
				end
				// Bytes after an overflow, start characters among them, are dropped.
				if (pick >= PICK_LATE_STAR && $urandom_range(0, 1) == 1) begin
					repeat ($urandom_range(1, 8))
						line.push_back(($urandom_range(0, 2) == 0) ? CH_START : body_char());
				end
				line.push_back(CH_NL);
			end
		end
		foreach (line[i])
			stim_q.push_back(line[i]);
	endfunction

	// Sends the queued bytes as requests in bursts with random gaps between them.
	task automatic send_stream();
		int unsigned burst;
		int unsigned gap;
		while (stim_q.size() != 0) begin
			burst = $urandom_range(1, 48);
			gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			while (burst != 0 && stim_q.size() != 0) begin
				in_ch.valid   <= 1'b1;
				in_ch.rx_byte <= stim_q[0];
				do
					@(posedge clk);
				while (!in_ch.ready);
				sb.note_rx_byte(stim_q.pop_front());
				bytes_sent++;
				burst--;
			end
			if (gap != 0) begin
				in_ch.valid   <= 1'b0;
				in_ch.rx_byte <= 8'($urandom_range(0, 255));
				repeat (gap) @(posedge clk);
			end
		end
		in_ch.valid <= 1'b0;
	endtask

	// Waits for every predicted result, then lets the pipeline empty.
	task automatic wait_idle();
		while (sb.pending_sentences.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic send_header_write(logic [CFG_IDX_W-1:0] idx, logic [HDR_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		sb.write_header(idx, data);
	endtask

	// Loads all four header words, plus writes to indexes the block must ignore.
	task automatic load_headers(logic [HDR_W-1:0] gga, logic [HDR_W-1:0] gsa,
			logic [HDR_W-1:0] rmc, logic [HDR_W-1:0] vtg);
		wait_idle();
		send_header_write(CFG_HDR_GGA, gga);
		send_header_write(CFG_HDR_GSA, gsa);
		send_header_write(CFG_HDR_RMC, rmc);
		send_header_write(CFG_HDR_VTG, vtg);
		send_header_write(CFG_IDX_W'(CFG_HDR_VTG + 1), rand_word());
		send_header_write(CFG_IDX_TOP, rand_word());
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase();
		while (stim_q.size() < PHASE_BYTES)
			add_sentence();
		send_stream();
	endtask

	initial begin
		logic [HDR_W-1:0] dup_word;
		sb = new();
		in_ch.valid   <= 1'b0;
		in_ch.rx_byte <= 8'h00;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= '0;
		cfg_ch.data   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset header words: lone newline, star at position zero, minimal valid
		// sentence with zero padding, restart in mid-sentence, a default GGA header.
		push_text("\n");
		push_text("*\n");
		push_text("$*00\n");
		push_text("$A$*00\n");
		push_text("$GPGGA*56\n");
		run_phase();

		// All-zero and all-one header words next to random ones.
		load_headers('0, ascii_header(), rand_word(), '1);
		run_phase();

		// Two equal words: the lower kind must win.
		dup_word = ascii_header();
		load_headers(dup_word, dup_word, "$GPRMC", ascii_header());
		run_phase();

		// Defaults written back explicitly.
		load_headers("$GPGGA", "$GPGSA", "$GPRMC", "$GPVTG");
		run_phase();

		wait_idle();
		$display("Sent %0d bytes under four header settings; %0d sentences, %0d results checked.",
			bytes_sent, sb.predicted, sb.checked);
		$display("Among them %0d checksum-valid, %0d overflowed, %0d restarted; kinds %0d/%0d/%0d/%0d/%0d.",
			sb.valid_count, sb.overflow_count, sb.restart_count, sb.kind_count[0],
			sb.kind_count[1], sb.kind_count[2], sb.kind_count[3], sb.kind_count[4]);
		if (sb.mismatches == 0 && sb.pending_sentences.size() == 0)
			$display("tb_nmea_sentence_checksum_framer_core: done, clean");
		else
			$display("tb_nmea_sentence_checksum_framer_core: done, errors");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(TIMEOUT_UNITS);
		$display("Timeout with %0d sentences still pending.", sb.pending_sentences.size());
		$display("tb_nmea_sentence_checksum_framer_core: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/nscf_pkg.sv
src/nscf_byte_if.sv
src/nscf_result_if.sv
src/nscf_cfg_if.sv
src/nmea_sentence_checksum_framer_core.sv
verif/nscf_sentence_sb_pkg.sv
verif/tb_nmea_sentence_checksum_framer_core.sv
